>>> src/rpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_pkg
// shared types and constants of the rgb pixel blend unit
// ----------------------------------------------------------------------------
package rpb_pkg;

    localparam int LANE_W      = 8;
    localparam int LANES       = 3;
    localparam int PIXEL_W     = LANE_W * LANES;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int TOP_MODE_W  = 2;
    localparam int LINE_MODE_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_COLOR  = 2'd0,
        REG_TOP_MODE     = 2'd1,
        REG_LINE_MODE    = 2'd2,
        REG_BLEND_AMOUNT = 2'd3
    } reg_index_t;

    typedef enum logic [TOP_MODE_W-1:0] {
        TOP_REPLACE = 2'd0,
        TOP_ADD     = 2'd1,
        TOP_AVERAGE = 2'd2,
        TOP_LINE    = 2'd3
    } top_mode_t;

    typedef enum logic [LINE_MODE_W-1:0] {
        LINE_REPLACE = 4'd0,
        LINE_ADD     = 4'd1,
        LINE_MAX     = 4'd2,
        LINE_AVERAGE = 4'd3,
        LINE_SUB     = 4'd4,
        LINE_RSUB    = 4'd5,
        LINE_MUL     = 4'd6,
        LINE_BLEND   = 4'd7,
        LINE_XOR     = 4'd8,
        LINE_MIN     = 4'd9
    } line_mode_t;

    // current blend settings as seen by the lanes
    typedef struct packed {
        logic [PIXEL_W-1:0]     color;
        top_mode_t              top_mode;
        logic [LINE_MODE_W-1:0] line_mode;
        logic [LANE_W-1:0]      amount;
    } blend_cfg_t;

    localparam logic [PIXEL_W-1:0] COLOR_RESET = 24'hFF_FFFF;

endpackage

>>> src/rpb_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module rpb_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rpb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output rpb_pkg::blend_cfg_t                 cfg
);

    rpb_pkg::blend_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color     <= rpb_pkg::COLOR_RESET;
            cfg_reg.top_mode  <= rpb_pkg::TOP_REPLACE;
            cfg_reg.line_mode <= rpb_pkg::LINE_REPLACE;
            cfg_reg.amount    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rpb_pkg::REG_BLEND_COLOR: begin
                    cfg_reg.color <= cfg_wdata[rpb_pkg::PIXEL_W-1:0];
                end
                rpb_pkg::REG_TOP_MODE: begin
                    cfg_reg.top_mode <=
                        rpb_pkg::top_mode_t'(cfg_wdata[rpb_pkg::TOP_MODE_W-1:0]);
                end
                rpb_pkg::REG_LINE_MODE: begin
                    cfg_reg.line_mode <= cfg_wdata[rpb_pkg::LINE_MODE_W-1:0];
                end
                rpb_pkg::REG_BLEND_AMOUNT: begin
                    cfg_reg.amount <= cfg_wdata[rpb_pkg::LANE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/rpb_lane_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpb_lane_alu
// blend of one pixel byte with one color byte
// ----------------------------------------------------------------------------
module rpb_lane_alu (
    input  logic [rpb_pkg::LANE_W-1:0]      pixel,
    input  logic [rpb_pkg::LANE_W-1:0]      color,
    input  rpb_pkg::blend_cfg_t             cfg,
    output logic [rpb_pkg::LANE_W-1:0]      result
);

    localparam int W  = rpb_pkg::LANE_W;
    localparam int PW = 2 * W;

    logic [W:0]    sum;
    logic [W-1:0]  sat_add;
    logic [W-1:0]  average;
    logic          p_gt_c;
    logic [W-1:0]  max_v;
    logic [W-1:0]  min_v;
    logic [W-1:0]  sub_v;
    logic [W-1:0]  rsub_v;
    logic [W-1:0]  inv_amount;
    logic [PW-1:0] mul_num;
    logic [PW-1:0] blend_num;
    logic [PW-1:0] num;
    logic [PW:0]   div_sum;
    logic [W-1:0]  quot;
    logic [W-1:0]  line_v;

    always_comb begin
        sum        = {1'b0, pixel} + {1'b0, color};
        sat_add    = sum[W] ? {W{1'b1}} : sum[W-1:0];
        average    = sum[W:1];
        p_gt_c     = pixel > color;
        max_v      = p_gt_c ? pixel : color;
        min_v      = p_gt_c ? color : pixel;
        sub_v      = p_gt_c ? pixel - color : '0;
        rsub_v     = p_gt_c ? '0 : color - pixel;
        inv_amount = ~cfg.amount;

        // numerators stay below 2^16 including the rounding term
        mul_num   = PW'(pixel) * PW'(color) + PW'(127);
        blend_num = PW'(color) * PW'(cfg.amount) + PW'(pixel) * PW'(inv_amount) + PW'(127);
        num       = (cfg.line_mode == rpb_pkg::LINE_MUL) ? mul_num : blend_num;

        // exact divide by 255 for numerators up to 255*255 + 127
        div_sum = {1'b0, num} + {{(W+1){1'b0}}, num[PW-1:W]} + (PW+1)'(1);
        quot    = div_sum[PW-1:W];
    end

    always_comb begin
        case (cfg.line_mode)
            rpb_pkg::LINE_REPLACE: line_v = color;
            rpb_pkg::LINE_ADD:     line_v = sat_add;
            rpb_pkg::LINE_MAX:     line_v = max_v;
            rpb_pkg::LINE_AVERAGE: line_v = average;
            rpb_pkg::LINE_SUB:     line_v = sub_v;
            rpb_pkg::LINE_RSUB:    line_v = rsub_v;
            rpb_pkg::LINE_MUL,
            rpb_pkg::LINE_BLEND:   line_v = quot;
            rpb_pkg::LINE_XOR:     line_v = pixel ^ color;
            // min, and the codes above it which fold onto min
            default:               line_v = min_v;
        endcase
    end

    always_comb begin
        case (cfg.top_mode)
            rpb_pkg::TOP_REPLACE: result = color;
            rpb_pkg::TOP_ADD:     result = sat_add;
            rpb_pkg::TOP_AVERAGE: result = average;
            rpb_pkg::TOP_LINE:    result = line_v;
            default:              result = color;
        endcase
    end

endmodule

>>> src/rgb_pixel_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// blends a three-byte framebuffer pixel with a configured 24-bit color
// ----------------------------------------------------------------------------
//
// channel   dir  ports                        content
// s_        in   s_tvalid s_tready s_tdata    pixel bytes 0..2
// m_        out  m_tvalid m_tready m_tdata    blended bytes 0..2
// cfg_      in   cfg_we cfg_index cfg_wdata   register writes, no read-back
//
// one pixel per clock sustained while m_tready stays high; the path runs from the input
// register to the result register, with the three lane blends between them
// aresetn is synchronous and active low; it empties both registers and
// loads the register defaults (white color, replace mode)
// a stall on m_ holds the result register; the input register still refills
// while the result register moves, so s_tready drops only when both are full
//
module rgb_pixel_blend_unit (
    input  logic                               aclk,
    input  logic                               aresetn,

    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rpb_pkg::PIXEL_W-1:0]        s_tdata,   // pixel_lane0, pixel_lane1, pixel_lane2

    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rpb_pkg::PIXEL_W-1:0]        m_tdata,   // out_lane0, out_lane1, out_lane2

    // configuration writes
    input  logic                               cfg_we,
    input  logic [rpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int W = rpb_pkg::LANE_W;

    rpb_pkg::blend_cfg_t cfg;

    // input register
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [rpb_pkg::PIXEL_W-1:0] in_data_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rpb_pkg::PIXEL_W-1:0] out_data_reg;

    logic [rpb_pkg::PIXEL_W-1:0] blended;
    logic                        advance;   // input register moves into result register
    logic                        s_accept;

    rpb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // one blend unit per byte lane, each against its own color byte
    for (genvar i = 0; i < rpb_pkg::LANES; i++) begin : g_lane
        rpb_lane_alu u_lane (
            .pixel  (in_data_reg[i*W +: W]),
            .color  (cfg.color[i*W +: W]),
            .cfg    (cfg),
            .result (blended[i*W +: W])
        );
    end

    // handshake control
    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        s_accept       = s_tvalid && s_tready;
        in_valid_next  = s_accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= blended;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an accepted transaction always lands in the input register
    a_accept_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted transaction not held in input register");

    // a pixel that moves on always shows up as a result
    a_advance_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced pixel missing on result stream");

    // replace mode hands the configured color straight through
    a_replace_color : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cfg.top_mode == rpb_pkg::TOP_REPLACE && !cfg_we
        |=> m_tdata == $past(cfg.color))
        else $error("replace mode result differs from blend color");

    // reset empties both registers
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
